/* hw/rtl/gvr_pkg.sv */
// Shared widths and latencies for the Givens rotation parameter pipeline.
package gvr_pkg;

  localparam int IN_W      = 32;                       // input component width
  localparam int FRAC_W    = 30;                       // output fraction bits
  localparam int OUT_W     = FRAC_W + 2;               // Q2.FRAC output width
  localparam int SQ_W      = 2 * IN_W - 1;             // |x|^2 <= 2^(2*IN_W-2)
  localparam int SUM_W     = 2 * IN_W;                 // a^2 + b^2 <= 2^(2*IN_W-1)
  localparam int REM_W     = SUM_W + 1;                // divider remainder after shift
  localparam int QUO_W     = 2 * FRAC_W + 3;           // quotient <= 2^(2*FRAC_W+2)
  localparam int DIV_STEPS = QUO_W;
  localparam int ROOT_W    = FRAC_W + 2;               // isqrt of quotient <= 2^(FRAC_W+1)
  localparam int RAD_W     = 2 * ROOT_W;               // radicand padded to even width
  localparam int SQR_REM_W = ROOT_W + 3;
  localparam int M_W       = FRAC_W + 1;               // rounded magnitude <= 2^FRAC_W
  localparam int RATIO_LAT = DIV_STEPS + ROOT_W;
  localparam int IN_DATA_W  = ((2 * IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic bzero;   // b is zero: identity rotation
    logic swap;    // |b| > |a|: sign goes on the cosine
    logic neg;     // signs differ and a is nonzero
  } gvr_flags_t;

endpackage

/* hw/rtl/givens_rotation_params_core.sv */
// Top level: streaming Givens rotation (c, s) generator, fully pipelined.
//
//  channel | dir | handshake              | tdata fields (low bit up)
//  --------+-----+------------------------+---------------------------------
//  in_     | in  | in_tvalid / in_tready  | a_value[31:0], b_value[63:32]
//  out_    | out | out_tvalid / out_tready| cos_value[31:0], sin_value[63:32]
//
// One transaction per cycle sustained unless the output stalls. Stages:
// magnitude stage, squaring, sum, 63 restoring-division stages (one quotient
// bit each), 32 square-root stages (one root bit each) and output register.
// Reset (rst_n low, synchronous) clears the valid bits only; datapath
// registers are not reset. A stall at the output freezes the whole pipe, so
// in_tready = !out_tvalid || out_tready; no transaction is dropped or repeated.
module givens_rotation_params_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gvr_pkg::IN_DATA_W-1:0]    in_tdata,   // a_value, b_value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gvr_pkg::OUT_DATA_W-1:0]   out_tdata   // cos_value, sin_value
);

  localparam int IW  = gvr_pkg::IN_W;
  localparam int OW  = gvr_pkg::OUT_W;
  localparam int LAT = gvr_pkg::RATIO_LAT;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage A: magnitudes and rotation flags
  logic [IW-1:0] a_in, b_in, ma, mb;
  logic          na, nb;
  assign a_in = in_tdata[IW-1:0];
  assign b_in = in_tdata[2*IW-1:IW];
  assign na   = a_in[IW-1];
  assign nb   = b_in[IW-1];
  assign ma   = na ? (IW'(0) - a_in) : a_in;
  assign mb   = nb ? (IW'(0) - b_in) : b_in;

  logic [IW-1:0]       ma_r, mb_r;
  gvr_pkg::gvr_flags_t fa_r;
  logic                va_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r       <= ma;
      mb_r       <= mb;
      fa_r.bzero <= (b_in == '0);
      fa_r.swap  <= (mb > ma);
      fa_r.neg   <= (na != nb) && (ma != '0);
    end
  end

  // stage B: squares
  logic [2*IW-1:0]            sqa_full, sqb_full;
  logic [gvr_pkg::SQ_W-1:0]   sqa_r, sqb_r;
  gvr_pkg::gvr_flags_t        fb_r;
  logic                       vb_r;
  assign sqa_full = ma_r * ma_r;
  assign sqb_full = mb_r * mb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r <= sqa_full[gvr_pkg::SQ_W-1:0];
      sqb_r <= sqb_full[gvr_pkg::SQ_W-1:0];
      fb_r  <= fa_r;
    end
  end

  // stage C: sum of squares
  logic [gvr_pkg::SQ_W-1:0]  sqa_c_r, sqb_c_r;
  logic [gvr_pkg::SUM_W-1:0] sum_r;
  gvr_pkg::gvr_flags_t       fc_r;
  logic                      vc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqa_c_r <= sqa_r;
      sqb_c_r <= sqb_r;
      sum_r   <= gvr_pkg::SUM_W'(sqa_r) + gvr_pkg::SUM_W'(sqb_r);
      fc_r    <= fb_r;
    end
  end

  // ratio pipelines, cosine and sine side by side
  logic [gvr_pkg::M_W-1:0] qc, qs;

  gvr_ratio u_cos (.clk(clk), .en(en), .num_sq(sqa_c_r), .sum_sq(sum_r), .mag(qc));
  gvr_ratio u_sin (.clk(clk), .en(en), .num_sq(sqb_c_r), .sum_sq(sum_r), .mag(qs));

  // flags and valid travel alongside the ratio stages
  gvr_pkg::gvr_flags_t fl_r [LAT];
  logic [LAT-1:0]      vl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= fc_r;
      for (int i = 1; i < LAT; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r       <= 1'b0;
      vb_r       <= 1'b0;
      vc_r       <= 1'b0;
      vl_r       <= '0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      va_r       <= in_tvalid;
      vb_r       <= va_r;
      vc_r       <= vb_r;
      vl_r       <= {vl_r[LAT-2:0], vc_r};
      out_tvalid <= vl_r[LAT-1];
    end
  end

  // output stage: sign placement and the b == 0 case
  gvr_pkg::gvr_flags_t fo;
  logic [OW-1:0]       qc_w, qs_w, cos_nxt, sin_nxt;
  logic [OW-1:0]       cos_r, sin_r;
  assign fo   = fl_r[LAT-1];
  assign qc_w = OW'(qc);
  assign qs_w = OW'(qs);

  always_comb begin
    if (fo.bzero) begin
      cos_nxt = OW'(1) << gvr_pkg::FRAC_W;
      sin_nxt = '0;
    end else if (fo.swap) begin
      cos_nxt = fo.neg ? (OW'(0) - qc_w) : qc_w;
      sin_nxt = qs_w;
    end else begin
      cos_nxt = qc_w;
      sin_nxt = fo.neg ? (OW'(0) - qs_w) : qs_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign out_tdata = gvr_pkg::OUT_DATA_W'({sin_r, cos_r});

endmodule

/* hw/rtl/gvr_ratio.sv */
// Pipelined round(num * 2^FRAC / sqrt(sum)): long division then integer square root.
module gvr_ratio (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gvr_pkg::SQ_W-1:0]    num_sq,
  input  logic [gvr_pkg::SUM_W-1:0]   sum_sq,
  output logic [gvr_pkg::M_W-1:0]     mag
);

  localparam int DS = gvr_pkg::DIV_STEPS;
  localparam int RS = gvr_pkg::ROOT_W;

  // X = floor(num^2 * 2^(2F+2) / sum), one quotient bit per stage
  logic [gvr_pkg::REM_W-1:0] div_rem_r [DS];
  logic [gvr_pkg::REM_W-1:0] div_den_r [DS];
  logic [gvr_pkg::QUO_W-1:0] div_quo_r [DS];

  genvar k;
  generate
    for (k = 0; k < DS; k++) begin : g_div
      logic [gvr_pkg::REM_W-1:0] rem_sh;
      logic [gvr_pkg::REM_W-1:0] den;
      logic [gvr_pkg::QUO_W-1:0] quo_in;
      logic                      ge;
      if (k == 0) begin : g_first
        assign rem_sh = gvr_pkg::REM_W'(num_sq);
        assign den    = gvr_pkg::REM_W'(sum_sq);
        assign quo_in = '0;
      end else begin : g_next
        assign rem_sh = {div_rem_r[k-1][gvr_pkg::REM_W-2:0], 1'b0};
        assign den    = div_den_r[k-1];
        assign quo_in = div_quo_r[k-1];
      end
      assign ge = (rem_sh >= den);
      always_ff @(posedge clk) begin
        if (en) begin
          div_rem_r[k] <= ge ? (rem_sh - den) : rem_sh;
          div_den_r[k] <= den;
          div_quo_r[k] <= {quo_in[gvr_pkg::QUO_W-2:0], ge};
        end
      end
    end
  endgenerate

  // r = isqrt(X), one root bit per stage
  logic [gvr_pkg::RAD_W-1:0]     sq_rad_r  [RS];
  logic [gvr_pkg::SQR_REM_W-1:0] sq_rem_r  [RS];
  logic [RS-1:0]                 sq_root_r [RS];

  genvar j;
  generate
    for (j = 0; j < RS; j++) begin : g_sqrt
      logic [gvr_pkg::RAD_W-1:0]     rad;
      logic [gvr_pkg::SQR_REM_W-1:0] rem_prev;
      logic [RS-1:0]                 root_prev;
      logic [gvr_pkg::SQR_REM_W-1:0] rem_in;
      logic [gvr_pkg::SQR_REM_W-1:0] trial;
      logic                          ge;
      if (j == 0) begin : g_first
        assign rad       = gvr_pkg::RAD_W'(div_quo_r[DS-1]);
        assign rem_prev  = '0;
        assign root_prev = '0;
      end else begin : g_next
        assign rad       = sq_rad_r[j-1];
        assign rem_prev  = sq_rem_r[j-1];
        assign root_prev = sq_root_r[j-1];
      end
      assign rem_in = {rem_prev[gvr_pkg::SQR_REM_W-3:0], rad[2*(RS-1-j) +: 2]};
      assign trial  = {gvr_pkg::SQR_REM_W'(root_prev) << 2} | gvr_pkg::SQR_REM_W'(1);
      assign ge     = (rem_in >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          sq_rad_r[j]  <= rad;
          sq_rem_r[j]  <= ge ? (rem_in - trial) : rem_in;
          sq_root_r[j] <= {root_prev[RS-2:0], ge};
        end
      end
    end
  endgenerate

  // largest m with (2m-1) <= r, i.e. (r+1)/2
  logic [RS-1:0] root_inc;
  assign root_inc = sq_root_r[RS-1] + RS'(1);
  assign mag      = root_inc[RS-1:1];

endmodule

/* hw/rtl/gvr_checker.sv */
// Port-level checks for the Givens rotation core, bound to the top level.
module gvr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [gvr_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [gvr_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int OW = gvr_pkg::OUT_W;

  logic signed [OW-1:0] cos_v, sin_v;
  assign cos_v = out_tdata[OW-1:0];
  assign sin_v = out_tdata[2*OW-1:OW];

  localparam logic signed [OW-1:0] ONE  = OW'(1) << gvr_pkg::FRAC_W;
  localparam logic signed [OW-1:0] MONE = -(OW'(1) << gvr_pkg::FRAC_W);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input changed while waiting");

  // pipe never blocks input when the output side is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with free output");

  // results stay within [-1, 1]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cos_v <= ONE && cos_v >= MONE && sin_v <= ONE && sin_v >= MONE)
    else $error("rotation value out of range");

  // reset clears the output valid
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid result after reset");

endmodule

bind givens_rotation_params_core gvr_checker u_gvr_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

/* sim/tb_givens_rotation_params_core.sv */
// Testbench for givens_rotation_params_core: random and directed stream traffic, scoreboard check.
module tb_givens_rotation_params_core;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;

  typedef struct packed {
    logic [gvr_pkg::OUT_W-1:0] sin_value;
    logic [gvr_pkg::OUT_W-1:0] cos_value;
  } rot_pair_t;

  // Expected-rotation store; computes (c, s) exactly with wide integers.
  class rotation_scoreboard;
    rot_pair_t rot_q[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // nearest integer to num * 2^FRAC_W / sqrt(sumsq)
    function logic [31:0] scaled_mag(logic [31:0] num, logic [63:0] sumsq);
      logic [159:0] rhs, lhs, n, odd, sq;
      logic [63:0]  lo, hi, mid;
      n = 160'(num);
      sq = 160'(sumsq);
      rhs = (n * n) << (2 * gvr_pkg::FRAC_W + 2);
      lo = '0;
      hi = 64'd1 << gvr_pkg::FRAC_W;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        odd = 160'((mid << 1) - 64'd1);
        lhs = odd * odd;
        lhs = lhs * sq;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 64'd1;
      end
      return lo[31:0];
    endfunction

    function void note_input(logic [gvr_pkg::IN_W-1:0] a, logic [gvr_pkg::IN_W-1:0] b);
      rot_pair_t   exp_rot;
      logic [31:0] ma, mb, qc, qs;
      logic [63:0] sumsq;
      logic        neg;
      if (b == '0) begin
        exp_rot.cos_value = gvr_pkg::OUT_W'(1) << gvr_pkg::FRAC_W;
        exp_rot.sin_value = '0;
      end else begin
        ma = a[gvr_pkg::IN_W-1] ? (~a + 32'd1) : a;
        mb = b[gvr_pkg::IN_W-1] ? (~b + 32'd1) : b;
        sumsq = 64'(ma) * 64'(ma) + 64'(mb) * 64'(mb);
        qc = scaled_mag(ma, sumsq);
        qs = scaled_mag(mb, sumsq);
        neg = (a[gvr_pkg::IN_W-1] != b[gvr_pkg::IN_W-1]) && (ma != '0);
        if (mb > ma) begin
          exp_rot.cos_value = neg ? -qc : qc;
          exp_rot.sin_value = qs;
        end else begin
          exp_rot.cos_value = qc;
          exp_rot.sin_value = neg ? -qs : qs;
        end
      end
      rot_q.push_back(exp_rot);
    endfunction

    function void check_result(rot_pair_t got);
      rot_pair_t exp_rot;
      if (rot_q.size() == 0) begin
        $display("%0t: unexpected result cos=%h sin=%h", $time, got.cos_value,
                 got.sin_value);
        errors++;
        return;
      end
      exp_rot = rot_q.pop_front();
      if (got.cos_value !== exp_rot.cos_value) begin
        $display("%0t: cos_value expected %h actual %h", $time, exp_rot.cos_value,
                 got.cos_value);
        errors++;
      end
      if (got.sin_value !== exp_rot.sin_value) begin
        $display("%0t: sin_value expected %h actual %h", $time, exp_rot.sin_value,
                 got.sin_value);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [gvr_pkg::IN_DATA_W-1:0]  in_tdata;   // a_value, b_value
  logic                           out_tvalid;
  logic                           out_tready;
  logic [gvr_pkg::OUT_DATA_W-1:0] out_tdata;  // cos_value, sin_value

  rotation_scoreboard rot_sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_cnt;

  givens_rotation_params_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver, result check and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        rot_sb.check_result(rot_pair_t'(out_tdata[2*gvr_pkg::OUT_W-1:0]));
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt > WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Drive one pair and hold it until accepted; idle cycles drawn one at a time.
  task automatic send_pair(logic [gvr_pkg::IN_W-1:0] a, logic [gvr_pkg::IN_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rot_sb.note_input(a, b);
  endtask

  task automatic send_random_pair();
    logic [gvr_pkg::IN_W-1:0] a, b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(9))
      0: b = '0;
      1: b = $urandom_range(1) ? a : -a;
      2: begin
        a = gvr_pkg::IN_W'($signed(16'($urandom)) >>> $urandom_range(15));
        b = gvr_pkg::IN_W'($signed(16'($urandom)) >>> $urandom_range(15));
      end
      3: a = $urandom_range(1) ? '0 : {1'b1, {(gvr_pkg::IN_W-1){1'b0}}};
      default: ;
    endcase
    send_pair(a, b);
  endtask

  localparam logic [gvr_pkg::IN_W-1:0] MAXV = {1'b0, {(gvr_pkg::IN_W-1){1'b1}}};
  localparam logic [gvr_pkg::IN_W-1:0] MINV = {1'b1, {(gvr_pkg::IN_W-1){1'b0}}};

  initial begin
    rot_sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    stall_cnt = 0;
    tx_idle_pct = 19;
    rx_idle_pct = 74;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero b, zero a, extremes, equal magnitudes, sign mixes
    send_pair(0, 0);        send_pair(5, 0);        send_pair(MINV, 0);
    send_pair(0, 7);        send_pair(0, MINV);     send_pair(0, -1);
    send_pair(MINV, MINV);  send_pair(MAXV, MAXV);  send_pair(MAXV, MINV);
    send_pair(MINV, MAXV);  send_pair(-1, 1);       send_pair(1, -1);
    send_pair(3, 4);        send_pair(-3, 4);       send_pair(4, -3);
    send_pair(MAXV, 1);     send_pair(1, MAXV);     send_pair(MINV, 1);
    send_pair(-1, MINV);    send_pair(MAXV, -MAXV); send_pair(100, -100);
    send_pair(-100, -100);  send_pair(MINV, -1);

    repeat (280) send_random_pair();
    tx_idle_pct = 74;
    rx_idle_pct = 19;
    repeat (280) send_random_pair();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (290) send_random_pair();
    in_tvalid <= 1'b0;

    while (rot_sb.rot_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rot_sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
